// ----- hdl/arop_pkg.sv -----
// Shared types for the attribute range option parser: parse phases, register indexes,
// the per-description parse state and the verdict handed to the result register.
// No dependencies.
`timescale 1ns / 1ps

package arop_pkg;

    localparam int unsigned VALUE_W = 31;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned OFS_W   = 3;

    typedef enum logic [1:0] {
        CFG_NAME_LOW,
        CFG_NAME_HIGH,
        CFG_NAME_LEN
    } t_cfg_reg;

    typedef enum logic [2:0] {
        PH_NAME,
        PH_DEAD,
        PH_OPT,
        PH_SKIP,
        PH_START,
        PH_ENDFIRST,
        PH_ENDDIGITS,
        PH_DONE
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic [POS_W-1:0]   char_position;
        logic [OFS_W-1:0]   option_offset;
        logic               name_mismatch;
        logic               digit_seen;
        logic [VALUE_W-1:0] start_acc;
        logic [VALUE_W-1:0] end_acc;
        logic               end_is_open;
        logic               range_done;
    } t_parse_state;

    localparam t_parse_state PARSE_CLEAR = '{
        phase:         PH_NAME,
        char_position: '0,
        option_offset: '0,
        name_mismatch: 1'b0,
        digit_seen:    1'b0,
        start_acc:     '0,
        end_acc:       '0,
        end_is_open:   1'b1,
        range_done:    1'b0
    };

    typedef struct packed {
        logic               type_matched;
        logic [VALUE_W-1:0] range_start;
        logic               range_open_end;
        logic [VALUE_W-1:0] range_end;
    } t_verdict;

endpackage

// ----- hdl/arop_step.sv -----
// One character step of the parser: next parse state and the verdict that
// a description ending on this character would get. Purely combinational.
// Depends on arop_pkg.
`timescale 1ns / 1ps

module arop_step #(
    parameter int unsigned NAME_CHARS = 16
) (
    input  arop_pkg::t_parse_state i_state,
    input  logic [7:0]             i_char,
    input  logic [63:0]            i_name_low,
    input  logic [63:0]            i_name_high,
    input  logic [4:0]             i_name_length,
    output arop_pkg::t_parse_state o_state,
    output arop_pkg::t_verdict     o_verdict
);

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [arop_pkg::VALUE_W-1:0] VALUE_MAX = '1;
    localparam logic [arop_pkg::OFS_W-1:0]   WORD_LAST = 3'd5;
    localparam logic [4:0] NAME_MAX = 5'(NAME_CHARS);

    // "range=" in lower case, one byte per option offset.
    localparam logic [7:0] RANGE_WORD [6] = '{8'h72, 8'h61, 8'h6E, 8'h67, 8'h65, 8'h3D};

    function automatic logic [7:0] fold(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    logic [7:0]  name_bytes [16];
    logic [4:0]  used_len;
    logic [7:0]  name_byte;
    logic        is_digit;
    logic        is_semi;
    logic        word_hit;
    logic [arop_pkg::VALUE_W-1:0] acc_in;
    logic [arop_pkg::VALUE_W+3:0] acc_sum;
    logic [arop_pkg::VALUE_W-1:0] acc_out;
    arop_pkg::t_parse_state n;
    logic        matched;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            name_bytes[i]     = i_name_low[8*i +: 8];
            name_bytes[i + 8] = i_name_high[8*i +: 8];
        end
    end

    assign used_len  = (i_name_length > NAME_MAX) ? NAME_MAX : i_name_length;
    assign name_byte = name_bytes[i_state.char_position[3:0]];
    assign is_digit  = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_semi   = (i_char == CH_SEMI);
    assign word_hit  = (i_state.option_offset <= WORD_LAST) &&
                       (fold(i_char) == RANGE_WORD[i_state.option_offset]);

    // One shared times-ten-plus-digit unit; the first end digit starts from zero.
    assign acc_in  = (i_state.phase == arop_pkg::PH_START)     ? i_state.start_acc :
                     (i_state.phase == arop_pkg::PH_ENDDIGITS) ? i_state.end_acc : '0;
    assign acc_sum = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0}
                   + {31'd0, i_char[3:0] - CH_ZERO[3:0]};
    assign acc_out = (acc_sum > {4'd0, VALUE_MAX}) ? VALUE_MAX
                                                   : acc_sum[arop_pkg::VALUE_W-1:0];

    always_comb begin
        n = i_state;
        unique case (i_state.phase)
            arop_pkg::PH_NAME: begin
                if (i_state.char_position < used_len) begin
                    if (fold(i_char) != fold(name_byte)) begin
                        n.name_mismatch = 1'b1;
                    end
                    n.char_position = i_state.char_position + 5'd1;
                end else if (is_semi && !i_state.name_mismatch) begin
                    n.phase         = arop_pkg::PH_OPT;
                    n.option_offset = '0;
                end else begin
                    n.phase = arop_pkg::PH_DEAD;
                end
            end
            arop_pkg::PH_OPT: begin
                if (word_hit) begin
                    n.option_offset = i_state.option_offset + 3'd1;
                    if (i_state.option_offset == WORD_LAST) begin
                        n.phase      = arop_pkg::PH_START;
                        n.start_acc  = '0;
                        n.digit_seen = 1'b0;
                    end
                end else begin
                    n.option_offset = '0;
                    n.phase = is_semi ? arop_pkg::PH_OPT : arop_pkg::PH_SKIP;
                end
            end
            arop_pkg::PH_SKIP: begin
                if (is_semi) begin
                    n.phase         = arop_pkg::PH_OPT;
                    n.option_offset = '0;
                end
            end
            arop_pkg::PH_START: begin
                if (is_digit) begin
                    n.start_acc  = acc_out;
                    n.digit_seen = 1'b1;
                end else if (i_char == CH_DASH && i_state.digit_seen) begin
                    n.phase = arop_pkg::PH_ENDFIRST;
                end else begin
                    n.option_offset = '0;
                    n.phase = is_semi ? arop_pkg::PH_OPT : arop_pkg::PH_SKIP;
                end
            end
            arop_pkg::PH_ENDFIRST: begin
                if (i_char == CH_STAR) begin
                    n.range_done  = 1'b1;
                    n.end_is_open = 1'b1;
                    n.phase       = arop_pkg::PH_DONE;
                end else if (is_digit) begin
                    n.range_done  = 1'b1;
                    n.end_is_open = 1'b0;
                    n.end_acc     = acc_out;
                    n.phase       = arop_pkg::PH_ENDDIGITS;
                end else begin
                    n.option_offset = '0;
                    n.phase = is_semi ? arop_pkg::PH_OPT : arop_pkg::PH_SKIP;
                end
            end
            arop_pkg::PH_ENDDIGITS: begin
                if (is_digit) begin
                    n.end_acc = acc_out;
                end else begin
                    n.phase = arop_pkg::PH_DONE;
                end
            end
            arop_pkg::PH_DEAD, arop_pkg::PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (n.phase == arop_pkg::PH_NAME) begin
            matched = !n.name_mismatch && (n.char_position == used_len);
        end else begin
            matched = (n.phase != arop_pkg::PH_DEAD);
        end
        o_verdict = '0;
        o_verdict.type_matched = matched;
        if (matched) begin
            if (n.range_done) begin
                o_verdict.range_start    = n.start_acc;
                o_verdict.range_open_end = n.end_is_open;
                o_verdict.range_end      = n.end_is_open ? '0 : n.end_acc;
            end else begin
                o_verdict.range_open_end = 1'b1;
            end
        end
    end

    assign o_state = n;

endmodule

// ----- hdl/attribute_range_option_parser_unit.sv -----
// Attribute range option parser, top level: input register, parse state,
// result register and name configuration registers.
// Depends on arop_pkg and arop_step.
//
// Usage: an attribute description enters one character per word on the input
// channel (i_valid / o_stall), i_last_char set on its final character. Only
// that final word yields a result on the output channel (o_valid / i_stall):
// whether the description names the configured attribute and the start and
// end of the first valid "range=" option. Other words yield nothing.
// Throughput is one word per cycle while o_stall is low, set by the parse step
// that updates the state between the input register and the result register.
// A last character accepted into the input register then has its verdict
// written into the result register for the receiver. While a result waits
// under i_stall, words that are not last still flow in; a last word then waits
// in the input register and o_stall rises. Reset (synchronous, active low)
// empties both registers, clears the parse state and loads the name "member"
// of length 6. The name registers are to be written through i_cfg_we /
// i_cfg_index / i_cfg_data only while idle; the block does not enforce this.
`timescale 1ns / 1ps

module attribute_range_option_parser_unit #(
    parameter int unsigned NAME_CHARS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_char,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_type_matched,
    output logic [30:0] o_range_start,
    output logic        o_range_open_end,
    output logic [30:0] o_range_end,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam logic [63:0] NAME_RESET    = 64'h0000_7265_626D_656D;
    localparam logic [4:0]  LEN_RESET     = 5'd6;

    logic [63:0] r_name_low;
    logic [63:0] r_name_high;
    logic [4:0]  r_name_len;

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_last;

    arop_pkg::t_parse_state r_state;
    arop_pkg::t_parse_state n_state;
    arop_pkg::t_verdict     n_verdict;
    arop_pkg::t_verdict     r_verdict;
    logic                   r_out_valid;

    logic advance;
    logic accept;

    // A last word can only move on when the result register is free.
    assign advance = r_in_valid && !(r_in_last && r_out_valid && i_stall);
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_low  <= NAME_RESET;
            r_name_high <= '0;
            r_name_len  <= LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                arop_pkg::CFG_NAME_LOW:  r_name_low  <= i_cfg_data;
                arop_pkg::CFG_NAME_HIGH: r_name_high <= i_cfg_data;
                arop_pkg::CFG_NAME_LEN:  r_name_len  <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_char <= i_char_code;
            r_in_last <= i_last_char;
        end
    end

    arop_step #(
        .NAME_CHARS(NAME_CHARS)
    ) u_step (
        .i_state      (r_state),
        .i_char       (r_in_char),
        .i_name_low   (r_name_low),
        .i_name_high  (r_name_high),
        .i_name_length(r_name_len),
        .o_state      (n_state),
        .o_verdict    (n_verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arop_pkg::PARSE_CLEAR;
        end else if (advance) begin
            r_state <= r_in_last ? arop_pkg::PARSE_CLEAR : n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_verdict <= n_verdict;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_type_matched   = r_verdict.type_matched;
    assign o_range_start    = r_verdict.range_start;
    assign o_range_open_end = r_verdict.range_open_end;
    assign o_range_end      = r_verdict.range_end;

endmodule

// ----- hdl/arop_checker.sv -----
// Port-level checks for the attribute range option parser, bound to the top level.
// Depends on attribute_range_option_parser_unit.
`timescale 1ns / 1ps

module arop_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_type_matched,
    input logic [30:0] o_range_start,
    input logic        o_range_open_end,
    input logic [30:0] o_range_end
);

    // A description that does not name the attribute carries no range.
    a_mismatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_type_matched |->
            o_range_start == 31'd0 && !o_range_open_end && o_range_end == 31'd0)
        else $error("mismatch result carries range fields");

    // An open end never reports a numeric end.
    a_open_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_range_open_end |-> o_range_end == 31'd0)
        else $error("open-ended range reports a nonzero end");

    // Input backpressure only arises while a result is held by the receiver.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a stalled result");

    // A result held under stall keeps its word.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_type_matched)
            && $stable(o_range_start) && $stable(o_range_open_end) && $stable(o_range_end))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result or stall present after reset");

endmodule

bind attribute_range_option_parser_unit arop_checker u_arop_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_type_matched  (o_type_matched),
    .o_range_start   (o_range_start),
    .o_range_open_end(o_range_open_end),
    .o_range_end     (o_range_end)
);

// ----- tb/tb_attribute_range_option_parser_unit.sv -----
// Self-checking testbench for attribute_range_option_parser_unit: directed and random
// attribute descriptions, checked against typed verdicts or a built-in parse predictor.
// Depends on arop_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_attribute_range_option_parser_unit;

    localparam int unsigned NAME_CHARS     = 16;
    localparam logic [30:0] VALUE_MAX      = 31'h7FFF_FFFF;
    localparam logic [63:0] RESET_NAME_LOW = 64'd125779768599917;
    localparam logic [47:0] RANGE_KEY      = "range=";
    localparam logic [7:0]  CH_SEMI        = ";";
    localparam logic [7:0]  CH_DASH        = "-";
    localparam logic [7:0]  CH_STAR        = "*";
    localparam logic [7:0]  CH_NUL         = 8'h00;
    localparam int          DIRECTED_ROWS  = 25;
    localparam int          PHASE_WORDS    = 100;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          WATCHDOG_LIMIT = 2000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic [7:0]  i_char_code = 8'h00;
    logic        i_last_char = 1'b0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic        o_type_matched;
    logic [30:0] o_range_start;
    logic        o_range_open_end;
    logic [30:0] o_range_end;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [63:0] i_cfg_data  = 64'd0;

    // Configuration as the block holds it.
    logic [63:0] attr_low  = RESET_NAME_LOW;
    logic [63:0] attr_high = 64'd0;
    logic [4:0]  attr_len  = 5'd6;

    // Parse state of the description in flight.
    arop_pkg::t_phase cur_phase = arop_pkg::PH_NAME;
    int          name_idx    = 0;
    int          key_idx     = 0;
    logic        name_bad    = 1'b0;
    logic        have_digit  = 1'b0;
    logic [30:0] lo_value    = '0;
    logic [30:0] hi_value    = '0;
    logic        hi_open     = 1'b1;
    logic        range_found = 1'b0;

    arop_pkg::t_verdict verdicts_due[$];
    logic [7:0]  desc_buf[$];
    int          words_sent   = 0;
    int          failures     = 0;
    int          stuck_cycles = 0;
    logic        quiet        = 1'b0;
    logic        hold_off_req = 1'b0;

    attribute_range_option_parser_unit #(
        .NAME_CHARS(NAME_CHARS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_char_code     (i_char_code),
        .i_last_char     (i_last_char),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_type_matched  (o_type_matched),
        .o_range_start   (o_range_start),
        .o_range_open_end(o_range_open_end),
        .o_range_end     (o_range_end),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [7:0] fold(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [30:0] accumulate(input logic [30:0] acc, input logic [7:0] c);
        logic [63:0] sum;
        sum = 64'(acc) * 64'd10 + 64'(c) - 64'd48;
        return (sum > 64'(VALUE_MAX)) ? VALUE_MAX : sum[30:0];
    endfunction

    function automatic int name_used();
        return (attr_len > NAME_CHARS) ? int'(NAME_CHARS) : int'(attr_len);
    endfunction

    function automatic logic [7:0] name_char(input int i);
        return (i < 8) ? attr_low[8*i +: 8] : attr_high[8*(i-8) +: 8];
    endfunction

    function automatic arop_pkg::t_verdict verdict(input logic m, input logic [30:0] s,
                                                   input logic o, input logic [30:0] e);
        arop_pkg::t_verdict v;
        v.type_matched   = m;
        v.range_start    = s;
        v.range_open_end = o;
        v.range_end      = e;
        return v;
    endfunction

    // A failed option either starts the next one at ';' or skips to it.
    task automatic drop_option(input logic [7:0] c);
        key_idx   = 0;
        cur_phase = (c == CH_SEMI) ? arop_pkg::PH_OPT : arop_pkg::PH_SKIP;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic last,
                              output logic gives, output arop_pkg::t_verdict v);
        logic [7:0] fc;
        logic       hit;
        fc    = fold(c);
        gives = 1'b0;
        v     = '0;
        case (cur_phase)
            arop_pkg::PH_NAME: begin
                if (name_idx < name_used()) begin
                    if (fc != fold(name_char(name_idx))) name_bad = 1'b1;
                    name_idx++;
                end else if (c == CH_SEMI && !name_bad) begin
                    cur_phase = arop_pkg::PH_OPT;
                    key_idx   = 0;
                end else begin
                    cur_phase = arop_pkg::PH_DEAD;
                end
            end
            arop_pkg::PH_OPT: begin
                if (key_idx < 6 && fc == RANGE_KEY[8*(5-key_idx) +: 8]) begin
                    key_idx++;
                    if (key_idx == 6) begin
                        cur_phase  = arop_pkg::PH_START;
                        lo_value   = '0;
                        have_digit = 1'b0;
                    end
                end else begin
                    drop_option(c);
                end
            end
            arop_pkg::PH_SKIP: begin
                if (c == CH_SEMI) begin
                    cur_phase = arop_pkg::PH_OPT;
                    key_idx   = 0;
                end
            end
            arop_pkg::PH_START: begin
                if (is_digit(c)) begin
                    lo_value   = accumulate(lo_value, c);
                    have_digit = 1'b1;
                end else if (c == CH_DASH && have_digit) begin
                    cur_phase = arop_pkg::PH_ENDFIRST;
                end else begin
                    drop_option(c);
                end
            end
            arop_pkg::PH_ENDFIRST: begin
                if (c == CH_STAR) begin
                    range_found = 1'b1;
                    hi_open     = 1'b1;
                    cur_phase   = arop_pkg::PH_DONE;
                end else if (is_digit(c)) begin
                    range_found = 1'b1;
                    hi_open     = 1'b0;
                    hi_value    = accumulate('0, c);
                    cur_phase   = arop_pkg::PH_ENDDIGITS;
                end else begin
                    drop_option(c);
                end
            end
            arop_pkg::PH_ENDDIGITS: begin
                if (is_digit(c)) hi_value = accumulate(hi_value, c);
                else cur_phase = arop_pkg::PH_DONE;
            end
            default: ;
        endcase
        if (last) begin
            gives = 1'b1;
            if (cur_phase == arop_pkg::PH_NAME) hit = !name_bad && name_idx == name_used();
            else hit = (cur_phase != arop_pkg::PH_DEAD);
            if (hit) begin
                v.type_matched   = 1'b1;
                v.range_open_end = !range_found || hi_open;
                if (range_found) begin
                    v.range_start = lo_value;
                    if (!hi_open) v.range_end = hi_value;
                end
            end
            cur_phase   = arop_pkg::PH_NAME;
            name_idx    = 0;
            key_idx     = 0;
            name_bad    = 1'b0;
            have_digit  = 1'b0;
            lo_value    = '0;
            hi_value    = '0;
            hi_open     = 1'b1;
            range_found = 1'b0;
        end
    endtask

    // Directed descriptions: name length in use and text, where '^' stands for a
    // NUL character. The verdict is typed in only where it is plain to see.
    task automatic directed_row(input int r, output int len, output string text,
                                output logic known, output arop_pkg::t_verdict want);
        known = 1'b0;
        want  = '0;
        len   = 6;
        case (r)
            0:  begin
                text  = "member";
                known = 1'b1;
                want  = verdict(1'b1, 31'd0, 1'b1, 31'd0);
            end
            1:  begin
                text  = "MeMbEr;RANGE=0-*";
                known = 1'b1;
                want  = verdict(1'b1, 31'd0, 1'b1, 31'd0);
            end
            2:  begin
                text  = "member;range=10-19";
                known = 1'b1;
                want  = verdict(1'b1, 31'd10, 1'b0, 31'd19);
            end
            3:  begin
                text  = "member;range=2147483648-99999999999";
                known = 1'b1;
                want  = verdict(1'b1, VALUE_MAX, 1'b0, VALUE_MAX);
            end
            4:  begin text = "members"; known = 1'b1; end
            5:  begin text = "membe"; known = 1'b1; end
            6:  begin text = "memxer;range=1-2"; known = 1'b1; end
            7:  text = "member;cn;range=3-*";
            8:  text = "member;range=5";
            9:  text = "member;range=-5;range=6-*";
            10: text = "member;range=5-x;range=6-7";
            11: text = "member;range=1-2;range=3-4";
            12: text = "member;range=7-8xyz;range=1-1";
            13: text = "member;rangex=1-2;Range=0-0";
            14: text = "member;range=^1-2;range=/1-:;range=1:-2";
            15: text = "member^";
            16: text = "member;@ANGE=1-2;[ange=3-4;{ANGE=5-6";
            17: text = "MEMBER;range=00042-0";
            18: begin len = 20; text = "member^^^^^^^^^^;range=4-5"; end
            19: begin len = 16; text = "MEMBER^^^^^^^^^^"; end
            20: begin len = 16; text = "member"; end
            21: begin len = 0; text = ";range=5-7"; end
            22: begin len = 0; text = "x"; known = 1'b1; end
            23: begin len = 0; text = ";"; end
            default: text = "member;";
        endcase
    endtask

    task automatic set_name(input logic [63:0] lo, input logic [63:0] hi, input logic [4:0] len);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= arop_pkg::CFG_NAME_LOW;
        i_cfg_data  <= lo;
        @(posedge i_clk);
        i_cfg_index <= arop_pkg::CFG_NAME_HIGH;
        i_cfg_data  <= hi;
        @(posedge i_clk);
        i_cfg_index <= arop_pkg::CFG_NAME_LEN;
        i_cfg_data  <= 64'(len);
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        attr_low  = lo;
        attr_high = hi;
        attr_len  = len;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_word(input logic [7:0] c, input logic last,
                             input logic has_typed, input arop_pkg::t_verdict typed);
        int       gap;
        logic     gives;
        arop_pkg::t_verdict v;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 13);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        i_last_char <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_sent++;
        parse_char(c, last, gives, v);
        if (gives) verdicts_due.push_back(has_typed ? typed : v);
    endtask

    task automatic send_description(input logic has_typed, input arop_pkg::t_verdict typed);
        int k;
        for (k = 0; k < desc_buf.size(); k++)
            send_word(desc_buf[k], k == desc_buf.size() - 1, has_typed, typed);
    endtask

    function automatic logic [7:0] mix_case(input logic [7:0] c);
        if (fold(c) >= "a" && fold(c) <= "z" && $urandom_range(0, 1) == 1) return c ^ 8'h20;
        return c;
    endfunction

    function automatic logic [63:0] letter_bytes();
        logic [63:0] w;
        for (int k = 0; k < 8; k++)
            w[8*k +: 8] = 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? "A" : "a");
        return w;
    endfunction

    // Mostly short numbers, now and then long enough to saturate.
    task automatic push_digits(input logic some);
        int n;
        n = !some ? 0 : ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
        repeat (n) desc_buf.push_back(8'(48 + $urandom_range(0, 9)));
    endtask

    task automatic push_option();
        int kind, k;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            for (k = 0; k < 6; k++) desc_buf.push_back(mix_case(RANGE_KEY[8*(5-k) +: 8]));
            if (kind == 6)
                desc_buf[$urandom_range(desc_buf.size() - 6, desc_buf.size() - 1)] = 8'($urandom);
            push_digits(kind != 5);
            if (kind != 4) desc_buf.push_back(CH_DASH);
            case ($urandom_range(0, 3))
                0:       desc_buf.push_back(CH_STAR);
                1:       desc_buf.push_back(8'($urandom));
                default: push_digits(1'b1);
            endcase
            if ($urandom_range(0, 3) == 0) desc_buf.push_back(8'($urandom));
        end else if (kind < 9) begin
            repeat ($urandom_range(0, 5)) desc_buf.push_back(8'($urandom_range(97, 122)));
        end else begin
            repeat ($urandom_range(1, 6)) desc_buf.push_back(8'($urandom));
        end
    endtask

    // Mostly the configured name followed by options; a few are noise or
    // carry a damaged, short or long name.
    task automatic build_description();
        int pick, k, idx;
        desc_buf.delete();
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            repeat ($urandom_range(1, 12)) desc_buf.push_back(8'($urandom));
            return;
        end
        for (k = 0; k < name_used(); k++) desc_buf.push_back(mix_case(name_char(k)));
        if (pick == 1 && desc_buf.size() != 0) begin
            idx = $urandom_range(0, desc_buf.size() - 1);
            desc_buf[idx] = desc_buf[idx] ^ 8'(1 << $urandom_range(0, 7));
        end else if (pick == 2 && desc_buf.size() != 0) begin
            void'(desc_buf.pop_back());
        end else if (pick == 3) begin
            desc_buf.push_back(8'($urandom));
        end
        repeat ($urandom_range(0, 3)) begin
            desc_buf.push_back(CH_SEMI);
            push_option();
        end
        if (desc_buf.size() == 0) desc_buf.push_back(CH_SEMI);
    endtask

    initial begin : stimulus
        int       r, k, len, ph, phase_end;
        string    text;
        logic     known;
        arop_pkg::t_verdict want;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < DIRECTED_ROWS; r++) begin
            directed_row(r, len, text, known, want);
            if (5'(len) != attr_len) begin
                drain();
                set_name(attr_low, attr_high, 5'(len));
            end
            desc_buf.delete();
            for (k = 0; k < text.len(); k++)
                desc_buf.push_back((text[k] == "^") ? CH_NUL : text[k]);
            send_description(known, want);
        end

        for (ph = 0; ph < 7; ph++) begin
            drain();
            case (ph)
                0: set_name({$urandom, $urandom}, {$urandom, $urandom}, 5'd16);
                1: set_name({$urandom, $urandom}, {$urandom, $urandom}, 5'd0);
                2: set_name(letter_bytes(), letter_bytes(), 5'd31);
                3: set_name('1, '1, 5'd1);
                4: set_name('0, '0, 5'd17);
                5: set_name(letter_bytes(), letter_bytes(), 5'($urandom_range(2, 15)));
                default: begin
                    quiet = 1'b1;
                    set_name(RESET_NAME_LOW, '0, 5'd6);
                end
            endcase
            // The receiver holds off once so that the block fills and stalls its input.
            if (ph == 0) hold_off_req = 1'b1;
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end) begin
                build_description();
                send_description(1'b0, '0);
            end
        end

        drain();
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : receiver
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : check_verdicts
        arop_pkg::t_verdict want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdicts_due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: verdict with none due: m=%0d s=%0d o=%0d e=%0d", $realtime,
                             o_type_matched, o_range_start, o_range_open_end, o_range_end);
            end else begin
                want = verdicts_due.pop_front();
                if (o_type_matched !== want.type_matched || o_range_start !== want.range_start ||
                    o_range_open_end !== want.range_open_end || o_range_end !== want.range_end) begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: verdict mismatch: want m=%0d s=%0d o=%0d e=%0d, %s%0d %0d %0d %0d",
                                 $realtime, want.type_matched, want.range_start,
                                 want.range_open_end, want.range_end, "got m/s/o/e ",
                                 o_type_matched, o_range_start, o_range_open_end, o_range_end);
                end
            end
        end
    end

    // Ends the run when no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) stuck_cycles <= 0;
        else stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
